### design/scol_pkg.sv
// package for the sorted cost open list
// holds sizes, entry and command types, status codes and controller states
// no dependencies
`timescale 1ns / 1ps

package scol_pkg;

  localparam int LIST_DEPTH  = 64;
  localparam int COST_BITS   = 24;
  localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
  localparam int PFX_LEVELS  = $clog2(LIST_DEPTH);
  localparam int COORD_W     = 8;
  localparam int FLAG_W      = 8;
  localparam int IN_COST_W   = 24;
  localparam int COUNT_OUT_W = 7;
  localparam int STATUS_W    = 2;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic [COORD_W-1:0]   px;
    logic [COORD_W-1:0]   py;
    logic [COST_BITS-1:0] cost;
    logic [FLAG_W-1:0]    flags;
  } entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic    eval;
    logic    apply;
    opcode_t opcode;
    entry_t  item;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_APPLY,
    ST_REPLY
  } fsm_t;

endpackage

### design/scol_if.sv
// channel interfaces of the sorted cost open list
// depends on scol_pkg for field widths
`timescale 1ns / 1ps

interface scol_in_if import scol_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [COORD_W-1:0]   node_x;
  logic [COORD_W-1:0]   node_y;
  logic [COORD_W-1:0]   parent_x;
  logic [COORD_W-1:0]   parent_y;
  logic [IN_COST_W-1:0] node_cost;
  logic [FLAG_W-1:0]    node_flags;

  modport source (output valid, opcode, node_x, node_y, parent_x, parent_y,
                  node_cost, node_flags, input ready);
  modport sink   (input valid, opcode, node_x, node_y, parent_x, parent_y,
                  node_cost, node_flags, output ready);
endinterface

interface scol_out_if import scol_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [COUNT_OUT_W-1:0] entry_count;
  logic [COORD_W-1:0]     head_x;
  logic [COORD_W-1:0]     head_y;
  logic [COORD_W-1:0]     head_parent_x;
  logic [COORD_W-1:0]     head_parent_y;
  logic [IN_COST_W-1:0]   head_cost;
  logic [FLAG_W-1:0]      head_flags;

  modport source (output valid, status, entry_count, head_x, head_y, head_parent_x,
                  head_parent_y, head_cost, head_flags, input ready);
  modport sink   (input valid, status, entry_count, head_x, head_y, head_parent_x,
                  head_parent_y, head_cost, head_flags, output ready);
endinterface

### design/scol_cell.sv
// one slot of the open list chain
// depends on scol_pkg for the entry and command types
`timescale 1ns / 1ps

module scol_cell import scol_pkg::*; (
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      valid_i,
  input  entry_t    left_entry,
  input  logic      left_pre,
  input  entry_t    right_entry,
  input  logic      pre_i,
  output logic      flag_o,
  output entry_t    entry_o
);

  entry_t entry_r;
  logic   flag_r;
  logic   flag_nxt;
  entry_t entry_nxt;

  always_comb begin
    unique case (cmd.opcode)
      OP_INSERT: begin
        // slot is at or past the insertion point
        flag_nxt  = !valid_i || (entry_r.cost >= cmd.item.cost);
        entry_nxt = left_pre ? left_entry : cmd.item;
      end
      OP_REMOVE: begin
        flag_nxt  = valid_i && (entry_r.x == cmd.item.x) && (entry_r.y == cmd.item.y);
        entry_nxt = right_entry;
      end
      default: begin
        flag_nxt  = 1'b0;
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      flag_r <= flag_nxt;
    end
    if (cmd.apply && pre_i) begin
      entry_r <= entry_nxt;
    end
  end

  assign flag_o  = flag_r;
  assign entry_o = entry_r;

endmodule

### design/scol_prefix.sv
// registered prefix or over the cell flags
// depends on scol_pkg for the list depth
`timescale 1ns / 1ps

module scol_prefix import scol_pkg::*; (
  input  logic                  clk,
  input  logic                  load,
  input  logic [LIST_DEPTH-1:0] flags_i,
  output logic [LIST_DEPTH-1:0] pre_o
);

  logic [LIST_DEPTH-1:0] lvl [PFX_LEVELS+1];
  logic [LIST_DEPTH-1:0] pre_r;

  assign lvl[0] = flags_i;

  // log-depth scan, distance doubles each level
  for (genvar k = 1; k <= PFX_LEVELS; k++) begin : g_lvl
    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_bit
      if (i >= (1 << (k - 1))) begin : g_or
        assign lvl[k][i] = lvl[k-1][i] | lvl[k-1][i - (1 << (k - 1))];
      end else begin : g_pass
        assign lvl[k][i] = lvl[k-1][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pre_r <= lvl[PFX_LEVELS];
    end
  end

  assign pre_o = pre_r;

endmodule

### design/sorted_cost_open_list.sv
// sorted cost open list: a chain of cells holding entries in ascending cost
// sequence per item: flag evaluate, prefix scan, chain shift, result load; the load
//   waits while the output is stalled, and the next item is taken in the cycle the
//   result is loaded, so only one item is in flight at a time
// reset: synchronous active-low rst_n empties the list and clears the output;
//   entry contents are not cleared, only slots below the count are used
`timescale 1ns / 1ps

module sorted_cost_open_list import scol_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  scol_in_if.sink    in_ch,
  scol_out_if.source out_ch
);

  // controller state
  fsm_t             state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  opcode_t          op_r;
  entry_t           item_r;
  status_t          status_r, status_nxt;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]    out_status_r;
  logic [COUNT_OUT_W-1:0] out_count_r;
  entry_t                 out_head_r;

  // handshake and phase strobes
  logic in_xfer;
  logic out_free;
  logic load_out;
  logic eval_en;
  logic scan_en;
  logic apply_en;
  logic list_full;
  logic found;
  logic do_change;

  // incoming entry, cost clamped to what a slot can hold
  entry_t                       in_item;
  logic [COST_BITS+IN_COST_W-1:0] cost_wide;
  logic [COST_BITS+IN_COST_W-1:0] cost_limit;

  // chain wiring
  cell_cmd_t             cmd;
  logic [LIST_DEPTH-1:0] valid_vec;
  logic [LIST_DEPTH-1:0] flag_vec;
  logic [LIST_DEPTH-1:0] pre_vec;
  entry_t                cell_q [LIST_DEPTH];

  // field extension helpers
  logic [CNT_W+COUNT_OUT_W-1:0]   count_ext;
  logic [IN_COST_W-1:0]           head_cost_ext_q;
  logic [COST_BITS+IN_COST_W-1:0] out_cost_ext;

  assign cost_wide  = {{COST_BITS{1'b0}}, in_ch.node_cost};
  assign cost_limit = {{IN_COST_W{1'b0}}, {COST_BITS{1'b1}}};

  always_comb begin
    in_item.x     = in_ch.node_x;
    in_item.y     = in_ch.node_y;
    in_item.px    = in_ch.parent_x;
    in_item.py    = in_ch.parent_y;
    in_item.cost  = (cost_wide > cost_limit) ? cost_limit[COST_BITS-1:0]
                                             : cost_wide[COST_BITS-1:0];
    in_item.flags = in_ch.node_flags;
  end

  // output slot can take a result this cycle
  assign out_free = !out_valid_r || out_ch.ready;

  // items are taken when idle, or while the previous result is being loaded
  assign in_ch.ready = (state_r == ST_IDLE) || ((state_r == ST_REPLY) && out_free);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  assign list_full = (count_r == CNT_W'(LIST_DEPTH));
  // prefix of the last slot is the or of every match flag
  assign found     = pre_vec[LIST_DEPTH-1];
  assign do_change = (op_r == OP_INSERT) ? !list_full : found;

  // sequencer: evaluate flags, scan prefix, shift chain, load result
  always_comb begin
    state_nxt  = state_r;
    eval_en    = 1'b0;
    scan_en    = 1'b0;
    apply_en   = 1'b0;
    load_out   = 1'b0;
    count_nxt  = count_r;
    status_nxt = status_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        eval_en   = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        scan_en   = 1'b1;
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        apply_en  = do_change;
        state_nxt = ST_REPLY;
        if (op_r == OP_INSERT) begin
          if (list_full) begin
            status_nxt = STAT_FULL;
          end else begin
            status_nxt = STAT_OK;
            count_nxt  = count_r + CNT_W'(1);
          end
        end else begin
          priority if (count_r == '0) begin
            status_nxt = STAT_EMPTY;
          end else if (!found) begin
            status_nxt = STAT_NOT_FOUND;
          end else begin
            status_nxt = STAT_OK;
            count_nxt  = count_r - CNT_W'(1);
          end
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = in_xfer ? ST_EVAL : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      status_r    <= STAT_OK;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
    end
  end

  // latched command of the item in flight
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r   <= opcode_t'(in_ch.opcode);
      item_r <= in_item;
    end
  end

  // count field carries the low bits; head fields read zero on an empty list
  assign count_ext = {{COUNT_OUT_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= status_r;
      out_count_r  <= count_ext[COUNT_OUT_W-1:0];
      out_head_r   <= (count_r == '0) ? '0 : cell_q[0];
    end
  end

  // registered head cost in the result field width
  assign out_cost_ext    = {{IN_COST_W{1'b0}}, out_head_r.cost};
  assign head_cost_ext_q = out_cost_ext[IN_COST_W-1:0];

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.entry_count   = out_count_r;
  assign out_ch.head_x        = out_head_r.x;
  assign out_ch.head_y        = out_head_r.y;
  assign out_ch.head_parent_x = out_head_r.px;
  assign out_ch.head_parent_y = out_head_r.py;
  assign out_ch.head_cost     = head_cost_ext_q;
  assign out_ch.head_flags    = out_head_r.flags;

  // command broadcast to the chain
  always_comb begin
    cmd.eval   = eval_en;
    cmd.apply  = apply_en;
    cmd.opcode = op_r;
    cmd.item   = item_r;
  end

  // slot i holds a live entry when it sits below the count
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_valid
    assign valid_vec[i] = (CNT_W'(i) < count_r);
  end

  // insert: slots at or past the point take the left neighbor, the first one the
  // new entry; remove: slots at or past the first match take the right neighbor
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_p;
    if (i == 0) begin : g_first
      assign left_e = item_r;
      assign left_p = 1'b0;
    end else begin : g_mid
      assign left_e = cell_q[i-1];
      assign left_p = pre_vec[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_last
      assign right_e = cell_q[i];
    end else begin : g_inner
      assign right_e = cell_q[i+1];
    end

    scol_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .valid_i    (valid_vec[i]),
      .left_entry (left_e),
      .left_pre   (left_p),
      .right_entry(right_e),
      .pre_i      (pre_vec[i]),
      .flag_o     (flag_vec[i]),
      .entry_o    (cell_q[i])
    );
  end

  // first-match scan across the chain
  scol_prefix u_prefix (
    .clk    (clk),
    .load   (scan_en),
    .flags_i(flag_vec),
    .pre_o  (pre_vec)
  );

endmodule

### design/scol_checker.sv
// port-level checks for the sorted cost open list
// depends on scol_pkg; bound to sorted_cost_open_list below
`timescale 1ns / 1ps

module scol_checker import scol_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [STATUS_W-1:0]    out_status,
  input logic [COUNT_OUT_W-1:0] out_entry_count,
  input logic [COORD_W-1:0]     out_head_x,
  input logic [IN_COST_W-1:0]   out_head_cost
);

  localparam logic [COUNT_OUT_W-1:0] DEPTH_LOW = COUNT_OUT_W'(LIST_DEPTH % 128);

  // stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_entry_count) && $stable(out_head_x))
    else $error("result changed while stalled");

  // an accepted item keeps the input closed while the chain works
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input reopened during an operation");

  // empty status leaves no entries and a cleared head
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_EMPTY) |->
      (out_entry_count == '0) && (out_head_x == '0) && (out_head_cost == '0))
    else $error("empty status with entries or head");

  // full status only with the list at capacity
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_FULL) |-> (out_entry_count == DEPTH_LOW))
    else $error("full status below capacity");

endmodule

bind sorted_cost_open_list scol_checker u_scol_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_entry_count(out_ch.entry_count),
  .out_head_x     (out_ch.head_x),
  .out_head_cost  (out_ch.head_cost)
);

### test/tb_sorted_cost_open_list.sv
// testbench for sorted_cost_open_list: inserts and removals against a sorted-array predictor
// depends on scol_pkg, the scol_in_if / scol_out_if channels and the design top level
`timescale 1ns / 1ps

module tb_sorted_cost_open_list;
  import scol_pkg::*;

  localparam logic [COST_BITS-1:0] COST_MAX = '1;

  typedef struct packed {
    opcode_t              op;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic [COORD_W-1:0]   px;
    logic [COORD_W-1:0]   py;
    logic [IN_COST_W-1:0] cost;
    logic [FLAG_W-1:0]    flags;
  } list_cmd_t;

  typedef struct packed {
    status_t                status;
    logic [COUNT_OUT_W-1:0] count;
    entry_t                 head;
  } list_reply_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  scol_in_if  in_if();
  scol_out_if out_if();

  sorted_cost_open_list u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // driver-side registers, known from time zero
  logic      in_valid_q  = 1'b0;
  list_cmd_t in_cmd_q    = '0;
  logic      out_ready_q = 1'b0;

  assign in_if.valid      = in_valid_q;
  assign in_if.opcode     = in_cmd_q.op;
  assign in_if.node_x     = in_cmd_q.x;
  assign in_if.node_y     = in_cmd_q.y;
  assign in_if.parent_x   = in_cmd_q.px;
  assign in_if.parent_y   = in_cmd_q.py;
  assign in_if.node_cost  = in_cmd_q.cost;
  assign in_if.node_flags = in_cmd_q.flags;
  assign out_if.ready     = out_ready_q;

  list_cmd_t   cmd_q[$];
  list_reply_t reply_q[$];
  logic [15:0] coord_pool[$];

  // predictor copy of the open list
  entry_t held[LIST_DEPTH];
  int     held_count = 0;

  int mismatch_count = 0;
  int in_gap_left    = 0;
  int in_calm        = 0;
  int out_stall_left = 0;
  int out_calm       = 0;

  // pause lengths: mostly short, a few long, with occasional pause-free stretches
  function automatic int next_pause(inout int calm);
    int r;
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // apply one accepted command to the held list and queue the reply it gives
  task automatic predict_open_list(input list_cmd_t c);
    list_reply_t r;
    entry_t      e;
    status_t     st;
    int          pos;
    int          i;
    pos = 0;
    if (c.op == OP_INSERT) begin
      if (held_count >= LIST_DEPTH) begin
        st = STAT_FULL;
      end else begin
        e.x     = c.x;
        e.y     = c.y;
        e.px    = c.px;
        e.py    = c.py;
        e.cost  = (c.cost > COST_MAX) ? COST_MAX : c.cost[COST_BITS-1:0];
        e.flags = c.flags;
        // goes in ahead of the first entry of equal or higher cost
        while (pos < held_count && e.cost > held[pos].cost) pos = pos + 1;
        for (i = held_count; i > pos; i = i - 1) held[i] = held[i-1];
        held[pos]  = e;
        held_count = held_count + 1;
        st = STAT_OK;
      end
    end else begin
      if (held_count == 0) begin
        st = STAT_EMPTY;
      end else begin
        while (pos < held_count && !(held[pos].x == c.x && held[pos].y == c.y))
          pos = pos + 1;
        if (pos == held_count) begin
          st = STAT_NOT_FOUND;
        end else begin
          for (i = pos; i < held_count - 1; i = i + 1) held[i] = held[i+1];
          held_count = held_count - 1;
          st = STAT_OK;
        end
      end
    end
    r.status = st;
    r.count  = held_count[COUNT_OUT_W-1:0];
    r.head   = (held_count > 0) ? held[0] : '0;
    reply_q.push_back(r);
  endtask

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatch_count = mismatch_count + 1;
    end
  endfunction

  // input driver: records the prediction on each transfer, then offers the next command
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid_q <= 1'b0;
    end else begin
      if (in_valid_q && in_if.ready) predict_open_list(in_cmd_q);
      if (!in_valid_q || in_if.ready) begin
        if (in_gap_left > 0) begin
          in_gap_left = in_gap_left - 1;
          in_valid_q <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          in_cmd_q    <= cmd_q.pop_front();
          in_valid_q  <= 1'b1;
          in_gap_left = next_pause(in_calm);
        end else begin
          in_valid_q <= 1'b0;
        end
      end
    end
  end

  // result monitor with random backpressure
  always @(posedge clk) begin
    list_reply_t exp_r;
    if (!rst_n) begin
      out_ready_q <= 1'b0;
    end else begin
      if (out_if.valid && out_ready_q) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0h count %0d",
                   $time, out_if.status, out_if.entry_count);
          mismatch_count = mismatch_count + 1;
        end else begin
          exp_r = reply_q.pop_front();
          check_field("status",        32'(exp_r.status),     32'(out_if.status));
          check_field("entry_count",   32'(exp_r.count),      32'(out_if.entry_count));
          check_field("head_x",        32'(exp_r.head.x),     32'(out_if.head_x));
          check_field("head_y",        32'(exp_r.head.y),     32'(out_if.head_y));
          check_field("head_parent_x", 32'(exp_r.head.px),    32'(out_if.head_parent_x));
          check_field("head_parent_y", 32'(exp_r.head.py),    32'(out_if.head_parent_y));
          check_field("head_cost",     32'(exp_r.head.cost),  32'(out_if.head_cost));
          check_field("head_flags",    32'(exp_r.head.flags), 32'(out_if.head_flags));
        end
      end
      if (out_stall_left > 0) begin
        out_stall_left = out_stall_left - 1;
        out_ready_q <= 1'b0;
      end else begin
        out_ready_q <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_stall_left = next_pause(out_calm);
      end
    end
  end

  task automatic add_insert(input logic [7:0] x, input logic [7:0] y, input logic [7:0] px,
                            input logic [7:0] py, input logic [23:0] cost,
                            input logic [7:0] flags);
    list_cmd_t c;
    c.op    = OP_INSERT;
    c.x     = x;
    c.y     = y;
    c.px    = px;
    c.py    = py;
    c.cost  = cost;
    c.flags = flags;
    cmd_q.push_back(c);
    coord_pool.push_back({x, y});
  endtask

  // payload fields of a removal are don't-care, so fill them with noise
  task automatic add_remove(input logic [7:0] x, input logic [7:0] y);
    list_cmd_t c;
    c.op    = OP_REMOVE;
    c.x     = x;
    c.y     = y;
    c.px    = 8'($urandom_range(0, 255));
    c.py    = 8'($urandom_range(0, 255));
    c.cost  = 24'($urandom_range(0, 24'hFFFFFF));
    c.flags = 8'($urandom_range(0, 255));
    cmd_q.push_back(c);
  endtask

  // small coordinates make duplicates and hits frequent
  function automatic logic [7:0] rand_coord();
    if ($urandom_range(0, 99) < 60) return 8'($urandom_range(0, 7));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [23:0] rand_cost();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 24'($urandom_range(0, 15));
    if (r < 25) return '0;
    if (r < 30) return COST_MAX;
    if (r < 45) return 24'($urandom_range(0, 4095));
    return 24'($urandom_range(0, 24'hFFFFFF));
  endfunction

  task automatic add_random_phase(input int n, input int insert_pct);
    int          k;
    int          idx;
    logic [15:0] xy;
    for (k = 0; k < n; k = k + 1) begin
      if ($urandom_range(0, 99) < insert_pct) begin
        add_insert(rand_coord(), rand_coord(), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), rand_cost(), 8'($urandom_range(0, 255)));
      end else if (coord_pool.size() > 0 && $urandom_range(0, 99) < 85) begin
        // target a coordinate that was inserted earlier
        idx = $urandom_range(0, coord_pool.size() - 1);
        xy  = coord_pool[idx];
        coord_pool[idx] = coord_pool[coord_pool.size() - 1];
        void'(coord_pool.pop_back());
        add_remove(xy[15:8], xy[7:0]);
      end else begin
        add_remove(rand_coord(), rand_coord());
      end
    end
  endtask

  initial begin
    // directed: empty list, field extremes, equal costs, partial matches
    add_remove(8'h00, 8'h00);
    add_remove(8'hFF, 8'hFF);
    add_insert(8'hFF, 8'hFF, 8'hFF, 8'hFF, COST_MAX, 8'hFF);
    add_insert(8'h00, 8'h00, 8'h00, 8'h00, 24'h000000, 8'h00);
    add_insert(8'h01, 8'h02, 8'hAA, 8'h55, 24'h000000, 8'hAA);
    add_insert(8'h03, 8'h04, 8'h55, 8'hAA, 24'h000100, 8'h55);
    add_insert(8'h04, 8'h05, 8'h0F, 8'hF0, COST_MAX, 8'h0F);
    add_insert(8'hAA, 8'h55, 8'hF0, 8'h0F, 24'hAAAAAA, 8'hF0);
    add_insert(8'h55, 8'hAA, 8'h33, 8'hCC, 24'h555555, 8'hCC);
    add_remove(8'h09, 8'h09);
    add_remove(8'hFF, 8'h00);
    add_remove(8'h00, 8'hFF);
    add_remove(8'h00, 8'h00);
    add_remove(8'h01, 8'h02);
    add_insert(8'h03, 8'h04, 8'h11, 8'h22, 24'h800000, 8'h81);
    add_remove(8'h03, 8'h04);
    add_remove(8'h03, 8'h04);
    add_remove(8'hAA, 8'h55);
    add_remove(8'h55, 8'hAA);
    add_remove(8'hFF, 8'hFF);
    add_remove(8'h04, 8'h05);
    add_remove(8'h03, 8'h04);
    add_remove(8'h04, 8'h05);
    coord_pool.delete();

    // random: fill past full, drain past empty, mixed, then again
    add_random_phase(100, 90);
    add_random_phase(110, 10);
    add_random_phase(100, 50);
    add_random_phase(100, 92);
    add_random_phase(90, 8);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() > 0 || in_valid_q || reply_q.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);

    if (mismatch_count == 0 && reply_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
